// ===== design/lsn_pkg.sv =====
// shared types, codes and defaults for the spiking network block
// no dependencies
package lsn_pkg;

  localparam int NeuronsDefault    = 64;
  localparam int SynapsesDefault   = 256;
  localparam int StdpWindowDefault = 20;

  localparam logic [1:0] CmdConnect = 2'd0;
  localparam logic [1:0] CmdInject  = 2'd1;
  localparam logic [1:0] CmdTick    = 2'd2;
  localparam logic [1:0] CmdRead    = 2'd3;

  localparam logic [2:0] RegFireThreshold = 3'd0;
  localparam logic [2:0] RegMembraneLimit = 3'd1;
  localparam logic [2:0] RegWeightLimit   = 3'd2;
  localparam logic [2:0] RegPotStep       = 3'd3;
  localparam logic [2:0] RegDepStep       = 3'd4;
  localparam logic [2:0] RegLeakShift     = 3'd5;

  localparam int InDataWidth  = 72;
  localparam int OutDataWidth = 128;

  typedef struct packed {
    logic signed [31:0] base;
    logic signed [48:0] delta;
    logic [30:0]        limit;
  } clamp_req_t;

endpackage

// ===== design/lsn_clamp.sv =====
// shared add and symmetric clamp unit
// depends on lsn_pkg
module lsn_clamp (
  input  lsn_pkg::clamp_req_t req,
  output logic signed [31:0]  result
);
  import lsn_pkg::*;

  logic signed [49:0] sum;
  logic signed [49:0] lim;

  always_comb begin
    sum = 50'(req.base) + 50'(req.delta);
    lim = $signed({19'd0, req.limit});
    if (sum > lim) begin
      result = 32'(lim);
    end else if (sum < -lim) begin
      result = 32'(-lim);
    end else begin
      result = sum[31:0];
    end
  end
endmodule

// ===== design/lsn_mul.sv =====
// registered signed multiplier for weight times payload
// depends on lsn_pkg
module lsn_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] product
);
  import lsn_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      product <= a * b;
    end
  end
endmodule

// ===== design/lif_spiking_network_stdp.sv =====
// top level: sequencer, state memories and result register of the spiking network
// depends on lsn_pkg, lsn_clamp, lsn_mul
//
// channel  direction  handshake                 payload
// s_axis   in         s_axis_tvalid/tready      command, neurons, value, synapse index
// m_axis   out        m_axis_tvalid/tready      accepted, new synapse, fired, weight, health, total
// cfg      in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// connect, read and inject end with a health scan over the S stored synapses; a tick
// walks all N neurons, the synapses of each fired neuron and all stored synapses, paced
// by the single membrane memory port, the synapse memory port and the shared clamp unit
// rst clears control state, the counters and the membrane and spike valid bits at once
// a transfer is taken only in idle; a finished result waits in the output register and
// the next command stalls at its end while m_axis holds off
module lif_spiking_network_stdp #(
  parameter int NEURONS     = lsn_pkg::NeuronsDefault,
  parameter int SYNAPSES    = lsn_pkg::SynapsesDefault,
  parameter int STDP_WINDOW = lsn_pkg::StdpWindowDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // command[1:0], first_neuron[11:2], second_neuron[21:12], value[53:22],
  // synapse_index[65:54], zero fill
  input  logic [lsn_pkg::InDataWidth-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // accepted[0], new_synapse[12:1], fired_count[23:13], weight_value[55:24],
  // healthy[56], spike_total[120:57], zero fill
  output logic [lsn_pkg::OutDataWidth-1:0]  m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        cfg_index,
  input  logic [31:0]                       cfg_data
);
  import lsn_pkg::*;

  localparam int NW = $clog2(NEURONS);
  localparam int SW = (SYNAPSES > 1) ? $clog2(SYNAPSES) : 1;
  localparam int CW = $clog2(SYNAPSES + 1);
  localparam int EW = 2 * NW + 32;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_INJ_WR = 5'd2;
  localparam logic [4:0] S_LF_RD  = 5'd3;
  localparam logic [4:0] S_LF_WR  = 5'd4;
  localparam logic [4:0] S_DL_F   = 5'd5;
  localparam logic [4:0] S_DL_SRD = 5'd6;
  localparam logic [4:0] S_DL_CHK = 5'd7;
  localparam logic [4:0] S_DL_ACC = 5'd8;
  localparam logic [4:0] S_ST_RD  = 5'd9;
  localparam logic [4:0] S_ST_TA  = 5'd10;
  localparam logic [4:0] S_ST_TB  = 5'd11;
  localparam logic [4:0] S_ST_UPD = 5'd12;
  localparam logic [4:0] S_ER_RD  = 5'd13;
  localparam logic [4:0] S_ER_CHK = 5'd14;
  localparam logic [4:0] S_HL_GO  = 5'd15;
  localparam logic [4:0] S_HL_RD  = 5'd16;
  localparam logic [4:0] S_HL_CHK = 5'd17;
  localparam logic [4:0] S_RD_GET = 5'd18;
  localparam logic [4:0] S_OUT    = 5'd19;

  logic [4:0] state;

  logic [30:0] fire_threshold, membrane_limit, weight_limit, pot_step, dep_step;
  logic [4:0]  leak_shift;

  logic [1:0]         cmd;
  logic [9:0]         n1, n2;
  logic signed [31:0] val;
  logic [11:0]        sidx;

  logic [CW-1:0] stored_count;
  logic [30:0]   step_time;
  logic [63:0]   spike_counter;
  logic [31:0]   error_counter;

  logic [NW-1:0] nidx, fidx;
  logic [SW-1:0] sreg;
  logic [NEURONS-1:0] mvalid, spike_valid, fired;
  logic          err_flag, health_ok;
  logic [30:0]   ta;

  logic          res_acc;
  logic [11:0]   res_nsyn;
  logic [10:0]   res_fc;
  logic [31:0]   res_wv;
  logic          out_valid, out_load;
  logic [OutDataWidth-1:0] out_data;

  // memories
  logic signed [31:0] mem_ram [NEURONS];
  logic [31:0]        pay_ram [NEURONS];
  logic [30:0]        time_ram [NEURONS];
  logic [EW-1:0]      syn_ram [SYNAPSES];

  logic               mem_re, mem_we, mem_rd_ok;
  logic [NW-1:0]      mem_ra, mem_wa;
  logic signed [31:0] mem_wd, mem_rd, mem_data;
  logic               pay_re, pay_we;
  logic [NW-1:0]      pay_a;
  logic [31:0]        pay_wd, pay_rd;
  logic               time_re, time_we;
  logic [NW-1:0]      time_ra;
  logic [30:0]        time_rd;
  logic               syn_re, syn_we;
  logic [SW-1:0]      syn_ra, syn_wa;
  logic [EW-1:0]      syn_wd, syn_rd;

  logic [NW-1:0]      syn_pre, syn_post;
  logic signed [31:0] syn_w;

  clamp_req_t         creq;
  logic signed [31:0] cres;
  logic               mul_en;
  logic signed [63:0] product;

  logic signed [31:0] v_shift, v_leak, v_pay;
  logic               v_fire;
  logic signed [31:0] dt, adt;
  logic               stdp_hit;
  logic [32:0]        v_abs;
  logic               w_bad, n1_ok, n2_ok, syn_full, rd_ok;
  logic               n_last, f_last, s_last;

  lsn_clamp u_clamp (.req(creq), .result(cres));
  lsn_mul u_mul (.clk(clk), .en(mul_en), .a(syn_w), .b($signed(pay_rd)), .product(product));

  assign syn_w    = $signed(syn_rd[31:0]);
  assign syn_post = syn_rd[NW+31:32];
  assign syn_pre  = syn_rd[2*NW+31:NW+32];
  assign mem_data = mem_rd_ok ? mem_rd : 32'sd0;

  assign n1_ok    = {1'b0, n1} < 11'(NEURONS);
  assign n2_ok    = {1'b0, n2} < 11'(NEURONS);
  assign syn_full = stored_count == CW'(SYNAPSES);
  assign rd_ok    = {1'b0, sidx} < 13'(stored_count);
  assign n_last   = nidx == NW'(NEURONS - 1);
  assign f_last   = fidx == NW'(NEURONS - 1);
  assign s_last   = (CW'(sreg) + CW'(1)) == stored_count;

  always_comb begin
    v_shift = mem_data >>> leak_shift;
    v_leak  = mem_data - v_shift;
    v_fire  = $signed({v_leak[31], v_leak}) >= $signed({2'b00, fire_threshold});
    v_pay   = v_leak - $signed({1'b0, fire_threshold});
    dt      = $signed({1'b0, time_rd}) - $signed({1'b0, ta});
    adt     = dt[31] ? -dt : dt;
    stdp_hit = spike_valid[syn_pre] && spike_valid[syn_post] && dt != 32'sd0 &&
               adt <= 32'(STDP_WINDOW);
    v_abs   = mem_data[31] ? -{mem_data[31], mem_data} : {mem_data[31], mem_data};
    w_bad   = ($signed({syn_w[31], syn_w}) > $signed({2'b00, weight_limit})) ||
              ($signed({syn_w[31], syn_w}) < -$signed({2'b00, weight_limit}));
  end

  always_comb begin
    mem_re = 1'b0; mem_ra = nidx; mem_we = 1'b0; mem_wa = nidx; mem_wd = cres;
    pay_re = 1'b0; pay_we = 1'b0; pay_a = fidx; pay_wd = v_pay;
    time_re = 1'b0; time_ra = syn_pre; time_we = 1'b0;
    syn_re = 1'b0; syn_ra = sreg; syn_we = 1'b0; syn_wa = sreg;
    syn_wd = {syn_pre, syn_post, cres};
    mul_en = 1'b0;
    creq.base = mem_data; creq.delta = 49'(val); creq.limit = membrane_limit;
    unique case (state)
      S_DISP: begin
        unique case (cmd)
          CmdConnect: begin
            creq.base = 32'sd0; creq.limit = weight_limit;
            syn_we = !syn_full && n1_ok && n2_ok;
            syn_wa = stored_count[SW-1:0];
            syn_wd = {n1[NW-1:0], n2[NW-1:0], cres};
          end
          CmdInject: begin
            mem_re = 1'b1; mem_ra = n1[NW-1:0];
          end
          CmdRead: begin
            syn_re = rd_ok; syn_ra = sidx[SW-1:0];
          end
          default: ;
        endcase
      end
      S_INJ_WR: begin
        mem_we = 1'b1; mem_wa = n1[NW-1:0];
      end
      S_LF_RD: mem_re = 1'b1;
      S_LF_WR: begin
        mem_we = 1'b1; mem_wa = nidx; mem_wd = v_fire ? 32'sd0 : v_leak;
        pay_we = v_fire; pay_a = nidx;
        time_we = v_fire;
      end
      S_DL_F:   pay_re = 1'b1;
      S_DL_SRD: syn_re = 1'b1;
      S_DL_CHK: begin
        mem_re = syn_pre == fidx; mem_ra = syn_post; mul_en = 1'b1;
      end
      S_DL_ACC: begin
        creq.delta = $signed(product[63:15]) >>> 1;
        mem_we = 1'b1; mem_wa = syn_post;
      end
      S_ST_RD:  syn_re = 1'b1;
      S_ST_TA:  time_re = 1'b1;
      S_ST_TB: begin
        time_re = 1'b1; time_ra = syn_post;
      end
      S_ST_UPD: begin
        creq.base = syn_w; creq.limit = weight_limit;
        creq.delta = (dt > 32'sd0) ? $signed({18'd0, pot_step}) : -$signed({18'd0, dep_step});
        syn_we = stdp_hit;
      end
      S_ER_RD:  mem_re = 1'b1;
      S_HL_RD:  syn_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_ram[mem_wa] <= mem_wd;
    if (mem_re) begin
      mem_rd    <= mem_ram[mem_ra];
      mem_rd_ok <= mvalid[mem_ra];
    end
    if (pay_we) pay_ram[pay_a] <= pay_wd;
    if (pay_re) pay_rd <= pay_ram[pay_a];
    if (time_we) time_ram[nidx] <= step_time;
    if (time_re) time_rd <= time_ram[time_ra];
    if (syn_we) syn_ram[syn_wa] <= syn_wd;
    if (syn_re) syn_rd <= syn_ram[syn_ra];
  end

  assign s_axis_tready = state == S_IDLE;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign out_load      = state == S_OUT && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fire_threshold <= 31'd65536; membrane_limit <= 31'd524288;
      weight_limit <= 31'd65536; pot_step <= 31'd1024; dep_step <= 31'd1024;
      leak_shift <= 5'd4;
      stored_count <= '0; step_time <= '0; spike_counter <= '0; error_counter <= '0;
      mvalid <= '0; spike_valid <= '0; fired <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          RegFireThreshold: fire_threshold <= cfg_data[30:0];
          RegMembraneLimit: membrane_limit <= cfg_data[30:0];
          RegWeightLimit:   weight_limit   <= cfg_data[30:0];
          RegPotStep:       pot_step       <= cfg_data[30:0];
          RegDepStep:       dep_step       <= cfg_data[30:0];
          RegLeakShift:     leak_shift     <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (mem_we) mvalid[mem_wa] <= 1'b1;

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            cmd  <= s_axis_tdata[1:0];
            n1   <= s_axis_tdata[11:2];
            n2   <= s_axis_tdata[21:12];
            val  <= $signed(s_axis_tdata[53:22]);
            sidx <= s_axis_tdata[65:54];
            res_acc <= 1'b1; res_nsyn <= '0; res_fc <= '0; res_wv <= '0;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          unique case (cmd)
            CmdConnect: begin
              if (syn_we) begin
                res_nsyn  <= 12'(stored_count);
                stored_count <= stored_count + CW'(1);
              end else begin
                res_acc <= 1'b0; error_counter <= error_counter + 32'd1;
              end
              state <= S_HL_GO;
            end
            CmdInject: begin
              if (n1_ok) begin
                state <= S_INJ_WR;
              end else begin
                res_acc <= 1'b0; error_counter <= error_counter + 32'd1;
                state <= S_HL_GO;
              end
            end
            CmdTick: begin
              nidx <= '0; fired <= '0; state <= S_LF_RD;
            end
            default: state <= rd_ok ? S_RD_GET : S_HL_GO;
          endcase
        end
        S_INJ_WR: state <= S_HL_GO;
        S_RD_GET: begin
          res_wv <= syn_w; state <= S_HL_GO;
        end
        S_LF_RD: state <= S_LF_WR;
        S_LF_WR: begin
          if (v_fire) begin
            fired[nidx] <= 1'b1; spike_valid[nidx] <= 1'b1;
            res_fc <= res_fc + 11'd1; spike_counter <= spike_counter + 64'd1;
          end
          if (n_last) begin
            fidx <= '0; state <= S_DL_F;
          end else begin
            nidx <= nidx + NW'(1); state <= S_LF_RD;
          end
        end
        S_DL_F: begin
          sreg <= '0;
          if (fired[fidx] && stored_count != '0) begin
            state <= S_DL_SRD;
          end else if (f_last) begin
            state <= S_ST_RD;
          end else begin
            fidx <= fidx + NW'(1);
          end
        end
        S_DL_SRD: state <= S_DL_CHK;
        S_DL_CHK, S_DL_ACC: begin
          if (state == S_DL_CHK && syn_pre == fidx) begin
            state <= S_DL_ACC;
          end else if (!s_last) begin
            sreg <= sreg + SW'(1); state <= S_DL_SRD;
          end else if (f_last) begin
            sreg <= '0; state <= S_ST_RD;
          end else begin
            fidx <= fidx + NW'(1); state <= S_DL_F;
          end
        end
        S_ST_RD: begin
          if (stored_count == '0) begin
            nidx <= '0; err_flag <= 1'b0; state <= S_ER_RD;
          end else begin
            state <= S_ST_TA;
          end
        end
        S_ST_TA: state <= S_ST_TB;
        S_ST_TB: begin
          ta <= time_rd; state <= S_ST_UPD;
        end
        S_ST_UPD: begin
          if (s_last) begin
            nidx <= '0; err_flag <= 1'b0; state <= S_ER_RD;
          end else begin
            sreg <= sreg + SW'(1); state <= S_ST_RD;
          end
        end
        S_ER_RD: state <= S_ER_CHK;
        S_ER_CHK: begin
          if (n_last) begin
            if (err_flag || v_abs > {2'b00, membrane_limit}) begin
              error_counter <= error_counter + 32'd1;
            end
            step_time <= step_time + 31'd1;
            state <= S_HL_GO;
          end else begin
            if (v_abs > {2'b00, membrane_limit}) err_flag <= 1'b1;
            nidx <= nidx + NW'(1); state <= S_ER_RD;
          end
        end
        S_HL_GO: begin
          health_ok <= 1'b1; sreg <= '0;
          state <= (stored_count == '0) ? S_OUT : S_HL_RD;
        end
        S_HL_RD: state <= S_HL_CHK;
        S_HL_CHK: begin
          if (w_bad) health_ok <= 1'b0;
          if (s_last) begin
            state <= S_OUT;
          end else begin
            sreg <= sreg + SW'(1); state <= S_HL_RD;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_data <= {7'd0, spike_counter, health_ok && error_counter == 32'd0,
                         res_wv, res_fc, res_nsyn, res_acc};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== tb/sv/tb_lif_spiking_network_stdp.sv =====
// testbench for the spiking network block: directed and random command streams,
// predicted results checked on m_axis by a scoreboard, several idle phases
// depends on lsn_pkg and lif_spiking_network_stdp
module tb_lif_spiking_network_stdp;
  timeunit 1ns;
  timeprecision 1ps;
  import lsn_pkg::*;

  localparam int NN = 64;
  localparam int NS = 256;
  localparam int WIN = 20;
  localparam int WATCHDOG = 400000;

  typedef struct packed {
    logic [11:0] sidx;
    logic [31:0] value;
    logic [9:0]  n2;
    logic [9:0]  n1;
    logic [1:0]  cmd;
  } net_cmd_t;

  typedef struct packed {
    logic [63:0] total;
    logic        healthy;
    logic [31:0] weight;
    logic [10:0] fired;
    logic [11:0] new_syn;
    logic        accepted;
  } net_rsp_t;

  class net_scoreboard;
    logic [30:0] thr, mlim, wlim, pot, dep;
    logic [4:0]  shift;
    logic signed [31:0] mem [NN];
    bit          sv [NN];
    logic [30:0] st [NN];
    int          pre [NS], post [NS];
    logic signed [31:0] w [NS];
    int          nsyn;
    logic [30:0] now;
    logic [63:0] spikes;
    logic [31:0] errs;
    net_rsp_t    pending [$];
    int          fails;

    function void clear();
      thr = 65536; mlim = 524288; wlim = 65536; pot = 1024; dep = 1024; shift = 4;
      foreach (mem[i]) begin
        mem[i] = 0; sv[i] = 0; st[i] = 0;
      end
      nsyn = 0; now = 0; spikes = 0; errs = 0; fails = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        RegFireThreshold: thr = d[30:0];
        RegMembraneLimit: mlim = d[30:0];
        RegWeightLimit:   wlim = d[30:0];
        RegPotStep:       pot = d[30:0];
        RegDepStep:       dep = d[30:0];
        RegLeakShift:     shift = d[4:0];
        default: ;
      endcase
    endfunction

    function longint clampv(longint v, logic [30:0] lim);
      longint l;
      l = lim;
      if (v > l) return l;
      if (v < -l) return -l;
      return v;
    endfunction

    function int run_step();
      int nf, fid [NN];
      longint fp [NN], v, dt, dv;
      nf = 0;
      foreach (mem[i]) begin
        v = mem[i];
        mem[i] = v - (v >>> shift);
      end
      foreach (mem[i]) begin
        if (longint'(mem[i]) >= longint'(thr)) begin
          fid[nf] = i; fp[nf] = longint'(mem[i]) - longint'(thr); nf++;
          mem[i] = 0; sv[i] = 1; st[i] = now; spikes++;
        end
      end
      for (int f = 0; f < nf; f++)
        for (int s = 0; s < nsyn; s++)
          if (pre[s] == fid[f]) begin
            dv = (longint'(w[s]) * longint'(int'(fp[f]))) >>> 16;
            mem[post[s]] = clampv(longint'(mem[post[s]]) + dv, mlim);
          end
      for (int s = 0; s < nsyn; s++) begin
        if (!sv[pre[s]] || !sv[post[s]]) continue;
        dt = longint'(st[post[s]]) - longint'(st[pre[s]]);
        if (dt == 0 || dt > WIN || dt < -WIN) continue;
        v = longint'(w[s]) + (dt > 0 ? longint'(pot) : -longint'(dep));
        w[s] = clampv(v, wlim);
      end
      foreach (mem[i]) begin
        v = mem[i];
        if (v < 0) v = -v;
        if (v > longint'(mlim)) begin
          errs++;
          break;
        end
      end
      now = now + 1;
      return nf;
    endfunction

    function void note_command(net_cmd_t c);
      net_rsp_t r;
      bit ok;
      r = '0;
      r.accepted = 1;
      case (c.cmd)
        CmdConnect: begin
          if (nsyn >= NS || c.n1 >= NN || c.n2 >= NN) begin
            r.accepted = 0; errs++;
          end else begin
            pre[nsyn] = c.n1; post[nsyn] = c.n2;
            w[nsyn] = clampv(longint'($signed(c.value)), wlim);
            r.new_syn = nsyn; nsyn++;
          end
        end
        CmdInject: begin
          if (c.n1 >= NN) begin
            r.accepted = 0; errs++;
          end else
            mem[c.n1] = clampv(longint'(mem[c.n1]) + longint'($signed(c.value)), mlim);
        end
        CmdTick: r.fired = run_step();
        default: if (c.sidx < nsyn) r.weight = w[c.sidx];
      endcase
      ok = (errs == 0);
      for (int s = 0; s < nsyn; s++)
        if (longint'(w[s]) > longint'(wlim) || longint'(w[s]) < -longint'(wlim)) ok = 0;
      r.healthy = ok;
      r.total = spikes;
      pending.push_back(r);
    endfunction

    function void check_result(net_rsp_t a);
      net_rsp_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", a);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (a.accepted !== e.accepted) begin
        $error("accepted exp %0d got %0d", e.accepted, a.accepted); fails++;
      end
      if (a.new_syn !== e.new_syn) begin
        $error("new_synapse exp %0d got %0d", e.new_syn, a.new_syn); fails++;
      end
      if (a.fired !== e.fired) begin
        $error("fired_count exp %0d got %0d", e.fired, a.fired); fails++;
      end
      if (a.weight !== e.weight) begin
        $error("weight_value exp %0d got %0d", $signed(e.weight), $signed(a.weight)); fails++;
      end
      if (a.healthy !== e.healthy) begin
        $error("healthy exp %0d got %0d", e.healthy, a.healthy); fails++;
      end
      if (a.total !== e.total) begin
        $error("spike_total exp %0d got %0d", e.total, a.total); fails++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [InDataWidth-1:0] s_axis_tdata;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  lif_spiking_network_stdp u_dut (.*);

  net_scoreboard sb;
  int send_idle, recv_stall, hold_off, quiet;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // sink: random stalls, optional long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 0;
    end else
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(net_rsp_t'(m_axis_tdata[120:0]));
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
  end

  initial begin
    wait (quiet >= WATCHDOG);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_cmd(logic [1:0] cmd, int n1, int n2, logic [31:0] value, int sidx);
    net_cmd_t c;
    c.cmd = cmd; c.n1 = n1; c.n2 = n2; c.value = value; c.sidx = sidx;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {{(InDataWidth - 66){1'b0}}, c};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_command(c);
    @(negedge clk);
    s_axis_tvalid <= 0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_cmd();
    int k, n1, n2;
    logic [31:0] v;
    k = $urandom_range(99);
    n1 = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(NN - 1);
    n2 = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(NN - 1);
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom_range(196608);
      2: v = -$urandom_range(131072);
      default: v = $urandom_range(65536);
    endcase
    if (k < 15) send_cmd(CmdConnect, n1, n2, v, 0);
    else if (k < 55) send_cmd(CmdInject, n1, 0, v, 0);
    else if (k < 80) send_cmd(CmdTick, 0, 0, 0, 0);
    else send_cmd(CmdRead, 0, 0, 0, $urandom_range(99) < 80 ? $urandom_range(sb.nsyn) :
                  $urandom_range(4095));
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst = 1; s_axis_tvalid = 0; s_axis_tdata = '0; m_axis_tready = 0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    send_idle = 0; recv_stall = 0; hold_off = 0; quiet = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_cmd(CmdConnect, 0, 1, 32'h7fffffff, 0);
    send_cmd(CmdConnect, 1, 0, 32'h80000000, 0);
    send_cmd(CmdConnect, 63, 2, 32'h00008000, 0);
    send_cmd(CmdConnect, 64, 1, 0, 0);
    send_cmd(CmdConnect, 2, 1023, 0, 0);
    send_cmd(CmdInject, 1023, 0, 1, 0);
    send_cmd(CmdInject, 0, 0, 32'h7fffffff, 0);
    send_cmd(CmdInject, 1, 0, 32'h80000000, 0);
    send_cmd(CmdInject, 63, 0, 32'h00030000, 0);
    send_cmd(CmdTick, 0, 0, 0, 0);
    send_cmd(CmdInject, 1, 0, 32'h00060000, 0);
    send_cmd(CmdTick, 0, 0, 0, 0);
    send_cmd(CmdTick, 0, 0, 0, 0);
    send_cmd(CmdRead, 0, 0, 0, 0);
    send_cmd(CmdRead, 0, 0, 0, 1);
    send_cmd(CmdRead, 0, 0, 0, 3);
    send_cmd(CmdRead, 0, 0, 0, 4095);

    // threshold of zero, full leak (shift of zero), extremes of the limits
    write_reg(RegFireThreshold, 0);
    write_reg(RegLeakShift, 0);
    write_reg(RegWeightLimit, 32'hffffffff);
    write_reg(RegMembraneLimit, 32'h7fffffff);
    write_reg(RegPotStep, 32'h7fffffff);
    write_reg(RegDepStep, 0);
    send_cmd(CmdTick, 0, 0, 0, 0);
    send_cmd(CmdTick, 0, 0, 0, 0);
    send_cmd(CmdRead, 0, 0, 0, 1);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 55; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 55; end
        default: begin send_idle = 27; recv_stall = 27; end
      endcase
      if (ph == 2) hold_off = 3000;
      write_reg(RegFireThreshold, ph == 5 ? 32'h7fffffff : $urandom_range(20000, 131072));
      write_reg(RegMembraneLimit, ph == 6 ? 0 : $urandom_range(200000, 2000000));
      write_reg(RegWeightLimit, ph == 6 ? 0 : $urandom_range(10000, 200000));
      write_reg(RegPotStep, $urandom_range(4096));
      write_reg(RegDepStep, ph == 7 ? 32'h7fffffff : $urandom_range(4096));
      write_reg(RegLeakShift, ph == 4 ? 31 : $urandom_range(8));
      repeat (70) random_cmd();
    end

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (sb.fails == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== lif_spiking_network_stdp.f =====
design/lsn_pkg.sv
design/lsn_clamp.sv
design/lsn_mul.sv
design/lif_spiking_network_stdp.sv
tb/sv/tb_lif_spiking_network_stdp.sv
